// File: design/qalu_pkg.sv
// Shared types, widths and arithmetic helpers of the quaternion ALU.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package qalu_pkg;

  // fixed-point format of one component
  localparam int WordBits  = 32;
  localparam int FracBits  = 16;
  localparam int TolBits   = 16;

  // derived widths
  localparam int MulOpBits = WordBits + 1;
  localparam int ProdBits  = 2 * MulOpBits;
  localparam int SatBits   = ProdBits + 4;
  localparam int SqBits    = 2 * WordBits;
  localparam int RootBits  = SqBits / 2;
  localparam int RemBits   = RootBits + 4;
  localparam int QuadBits  = SqBits - FracBits;
  localparam int DivBits   = QuadBits;
  localparam int NumBits   = WordBits + FracBits;
  localparam int QuoBits   = WordBits + 1;

  localparam logic signed [MulOpBits-1:0] OneFix = MulOpBits'(1) <<< FracBits;

  typedef enum logic [2:0] {
    FUNC_MUL   = 3'd0,
    FUNC_ADD   = 3'd1,
    FUNC_SUB   = 3'd2,
    FUNC_SCALE = 3'd3,
    FUNC_CONJ  = 3'd4,
    FUNC_INV   = 3'd5,
    FUNC_NORM  = 3'd6,
    FUNC_NLERP = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_INV = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  // element 0 is the scalar part, then x, y, z
  typedef logic [3:0][WordBits-1:0] quat_t;

  typedef struct packed {
    func_e                func;
    quat_t                a;
    quat_t                b;
    logic [WordBits-1:0]  w;
  } item_t;

  typedef struct packed {
    func_e              func;
    quat_t              v;
    logic               flag;
    logic [SqBits-1:0]  s;
  } front_t;

  typedef struct packed {
    func_e                func;
    quat_t                v;
    logic                 flag;
    logic [QuadBits-1:0]  quad;
  } side_t;

  typedef struct packed {
    quat_t    r;
    status_e  status;
  } res_t;

  typedef struct packed {
    logic [WordBits-1:0]  val;
    logic                 ovf;
  } sat_t;

  // clamp a wide signed value to the word range
  function automatic sat_t sat_word(input logic signed [SatBits-1:0] x);
    sat_t res;
    logic [SatBits-WordBits:0] top;
    top     = x[SatBits-1:WordBits-1];
    res.ovf = !(&top) && (|top);
    if (res.ovf) begin
      res.val = x[SatBits-1] ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
    end else begin
      res.val = x[WordBits-1:0];
    end
    return res;
  endfunction

  // sign-extend a word to the wide format
  function automatic logic signed [SatBits-1:0] sxw(input logic [WordBits-1:0] v);
    logic signed [WordBits-1:0] s;
    s = $signed(v);
    return SatBits'(s);
  endfunction

  // sign-extend a word to a multiplier operand
  function automatic logic signed [MulOpBits-1:0] sxm(input logic [WordBits-1:0] v);
    logic signed [WordBits-1:0] s;
    s = $signed(v);
    return MulOpBits'(s);
  endfunction

  // product scaled back by the fraction bits, rounding toward minus infinity
  function automatic logic signed [SatBits-1:0] fl(input logic signed [ProdBits-1:0] p);
    logic signed [ProdBits-FracBits-1:0] sh;
    sh = (ProdBits-FracBits)'(p >>> FracBits);
    return SatBits'(sh);
  endfunction

endpackage

`default_nettype wire

// File: design/qalu_front.sv
// Front pipeline of the quaternion ALU: multipliers, term reduction, blend,
// squares and squared sum (six register stages). Uses qalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qalu_front import qalu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_vld_i,
  input  item_t   in_i,
  output logic    out_vld_o,
  output front_t  out_o
);

  logic [5:0] vld_q;

  // valid bits travel with the words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], in_vld_i};
    end
  end

  // stage 1: input capture
  item_t s1_q;
  always_ff @(posedge clk_i) begin
    s1_q <= in_i;
  end

  // stage 2: sixteen multiplier lanes, operands picked by function
  logic signed [MulOpBits-1:0] ma [16];
  logic signed [MulOpBits-1:0] mb [16];
  logic signed [MulOpBits-1:0] k0;

  always_comb begin
    k0 = OneFix - sxm(s1_q.w);
    for (int k = 0; k < 16; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    unique case (s1_q.func)
      FUNC_MUL: begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            ma[4*i+j] = sxm(s1_q.a[i]);
            mb[4*i+j] = sxm(s1_q.b[j]);
          end
        end
      end
      FUNC_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          ma[i] = sxm(s1_q.a[i]);
          mb[i] = sxm(s1_q.w);
        end
      end
      FUNC_NLERP: begin
        for (int i = 0; i < 4; i++) begin
          ma[i]   = sxm(s1_q.a[i]);
          mb[i]   = sxm(s1_q.b[i]);
          ma[4+i] = sxm(s1_q.a[i]);
          mb[4+i] = k0;
          ma[8+i] = sxm(s1_q.b[i]);
          mb[8+i] = sxm(s1_q.w);
        end
      end
      default: begin
      end
    endcase
  end

  func_e                       s2_func_q;
  quat_t                       s2_a_q;
  quat_t                       s2_b_q;
  logic signed [ProdBits-1:0]  s2_p_q [16];

  always_ff @(posedge clk_i) begin
    s2_func_q <= s1_q.func;
    s2_a_q    <= s1_q.a;
    s2_b_q    <= s1_q.b;
    for (int k = 0; k < 16; k++) begin
      s2_p_q[k] <= ma[k] * mb[k];
    end
  end

  // stage 3: floor the products, sum terms, simple ops finish here
  logic signed [SatBits-1:0] ft [16];
  logic signed [SatBits-1:0] hs [4];
  logic signed [SatBits-1:0] dot;
  logic                      dot_pos;
  logic signed [SatBits-1:0] na_d [4];
  logic signed [SatBits-1:0] nb_d [4];
  sat_t                      sr3 [4];
  quat_t                     s3_v_d;
  logic                      s3_flag_d;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      ft[k] = fl(s2_p_q[k]);
    end
    hs[0] = ft[0] - ft[5] - ft[10] - ft[15];
    hs[1] = ft[1] + ft[4] + ft[11] - ft[14];
    hs[2] = ft[2] + ft[8] + ft[13] - ft[7];
    hs[3] = ft[3] + ft[12] + ft[6] - ft[9];
    dot = SatBits'(s2_p_q[0]) + SatBits'(s2_p_q[1]) + SatBits'(s2_p_q[2])
        + SatBits'(s2_p_q[3]);
    dot_pos = !dot[SatBits-1] && (|dot);
    for (int i = 0; i < 4; i++) begin
      na_d[i] = ft[4+i];
      nb_d[i] = dot_pos ? ft[8+i] : fl(-s2_p_q[8+i]);
    end
    for (int i = 0; i < 4; i++) begin
      unique case (s2_func_q)
        FUNC_MUL:   sr3[i] = sat_word(hs[i]);
        FUNC_ADD:   sr3[i] = sat_word(sxw(s2_a_q[i]) + sxw(s2_b_q[i]));
        FUNC_SUB:   sr3[i] = sat_word(sxw(s2_a_q[i]) - sxw(s2_b_q[i]));
        FUNC_SCALE: sr3[i] = sat_word(ft[i]);
        FUNC_CONJ: begin
          if (i == 0) begin
            sr3[i] = '{val: s2_a_q[i], ovf: 1'b0};
          end else begin
            sr3[i] = sat_word(-sxw(s2_a_q[i]));
          end
        end
        default:    sr3[i] = '{val: s2_a_q[i], ovf: 1'b0};
      endcase
    end
    s3_flag_d = 1'b0;
    for (int i = 0; i < 4; i++) begin
      s3_v_d[i] = sr3[i].val;
      s3_flag_d = s3_flag_d | sr3[i].ovf;
    end
  end

  func_e                      s3_func_q;
  quat_t                      s3_v_q;
  logic                       s3_flag_q;
  logic signed [SatBits-1:0]  s3_na_q [4];
  logic signed [SatBits-1:0]  s3_nb_q [4];

  always_ff @(posedge clk_i) begin
    s3_func_q <= s2_func_q;
    s3_v_q    <= s3_v_d;
    s3_flag_q <= s3_flag_d;
    for (int i = 0; i < 4; i++) begin
      s3_na_q[i] <= na_d[i];
      s3_nb_q[i] <= nb_d[i];
    end
  end

  // stage 4: nlerp blend, saturated before normalizing
  sat_t   sr4 [4];
  quat_t  s4_v_d;
  logic   s4_flag_d;

  always_comb begin
    s4_v_d    = s3_v_q;
    s4_flag_d = s3_flag_q;
    for (int i = 0; i < 4; i++) begin
      sr4[i] = sat_word(s3_na_q[i] + s3_nb_q[i]);
    end
    if (s3_func_q == FUNC_NLERP) begin
      for (int i = 0; i < 4; i++) begin
        s4_v_d[i] = sr4[i].val;
        s4_flag_d = s4_flag_d | sr4[i].ovf;
      end
    end
  end

  func_e  s4_func_q;
  quat_t  s4_v_q;
  logic   s4_flag_q;

  always_ff @(posedge clk_i) begin
    s4_func_q <= s3_func_q;
    s4_v_q    <= s4_v_d;
    s4_flag_q <= s4_flag_d;
  end

  // stage 5: component squares
  logic signed [WordBits-1:0] vs [4];
  logic signed [SqBits-1:0]   sq_d [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vs[i]   = $signed(s4_v_q[i]);
      sq_d[i] = vs[i] * vs[i];
    end
  end

  func_e              s5_func_q;
  quat_t              s5_v_q;
  logic               s5_flag_q;
  logic [SqBits-1:0]  s5_sq_q [4];

  always_ff @(posedge clk_i) begin
    s5_func_q <= s4_func_q;
    s5_v_q    <= s4_v_q;
    s5_flag_q <= s4_flag_q;
    for (int i = 0; i < 4; i++) begin
      s5_sq_q[i] <= sq_d[i];
    end
  end

  // stage 6: squared sum, clamped to the unsigned range
  logic [SqBits+1:0] ssum;
  front_t            out_d;
  front_t            out_q;

  always_comb begin
    ssum = (SqBits+2)'(s5_sq_q[0]) + (SqBits+2)'(s5_sq_q[1])
         + (SqBits+2)'(s5_sq_q[2]) + (SqBits+2)'(s5_sq_q[3]);
    out_d.func = s5_func_q;
    out_d.v    = s5_v_q;
    out_d.flag = s5_flag_q;
    out_d.s    = (|ssum[SqBits+1:SqBits]) ? {SqBits{1'b1}} : ssum[SqBits-1:0];
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_vld_o = vld_q[5];
  assign out_o     = out_q;

endmodule

`default_nettype wire

// File: design/qalu_sqrt.sv
// Pipelined integer square root of the squared sum, one root bit per stage.
// Carries the item's side data alongside. Uses qalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qalu_sqrt import qalu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_vld_i,
  input  front_t               in_i,
  output logic                 out_vld_o,
  output side_t                out_side_o,
  output logic [RootBits-1:0]  out_len_o
);

  logic [RootBits-1:0]  vld_q;
  logic [SqBits-1:0]    rad_q  [RootBits];
  logic [RemBits-1:0]   rem_q  [RootBits];
  logic [RootBits-1:0]  root_q [RootBits];
  side_t                side_q [RootBits];

  logic [SqBits-1:0]    rad_d  [RootBits];
  logic [RemBits-1:0]   rem_d  [RootBits];
  logic [RootBits-1:0]  root_d [RootBits];
  side_t                side_d [RootBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[RootBits-2:0], in_vld_i};
    end
  end

  // one restoring step per stage: two radicand bits in, one root bit out
  always_comb begin
    logic [SqBits-1:0]   rad_in;
    logic [RemBits-1:0]  rem_in;
    logic [RootBits-1:0] root_in;
    logic [RemBits-1:0]  r;
    logic [RemBits-1:0]  t;
    for (int k = 0; k < RootBits; k++) begin
      if (k == 0) begin
        rad_in    = in_i.s;
        rem_in    = '0;
        root_in   = '0;
        side_d[k] = '{func: in_i.func, v: in_i.v, flag: in_i.flag,
                      quad: in_i.s[SqBits-1:FracBits]};
      end else begin
        rad_in    = rad_q[k-1];
        rem_in    = rem_q[k-1];
        root_in   = root_q[k-1];
        side_d[k] = side_q[k-1];
      end
      r = {rem_in[RemBits-3:0], rad_in[SqBits-1:SqBits-2]};
      t = RemBits'({root_in, 2'b01});
      rad_d[k] = {rad_in[SqBits-3:0], 2'b00};
      if (r >= t) begin
        rem_d[k]  = r - t;
        root_d[k] = {root_in[RootBits-2:0], 1'b1};
      end else begin
        rem_d[k]  = r;
        root_d[k] = {root_in[RootBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RootBits; k++) begin
      rad_q[k]  <= rad_d[k];
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      side_q[k] <= side_d[k];
    end
  end

  assign out_vld_o  = vld_q[RootBits-1];
  assign out_side_o = side_q[RootBits-1];
  assign out_len_o  = root_q[RootBits-1];

endmodule

`default_nettype wire

// File: design/qalu_div.sv
// Divider pipeline of the quaternion ALU: operand setup, one quotient bit per
// stage on four lanes, then saturation and result select. Uses qalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qalu_div import qalu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_vld_i,
  input  side_t                in_side_i,
  input  logic [RootBits-1:0]  in_len_i,
  input  logic [TolBits-1:0]   tol_i,
  output logic                 out_vld_o,
  output res_t                 out_o
);

  typedef struct packed {
    logic [DivBits-1:0]  rem;
    logic [QuoBits-1:0]  lq;
    logic                neg;
    logic                big;
  } lane_t;

  typedef struct packed {
    quat_t  v;
    logic   flag;
    logic   zero;
    logic   do_div;
  } dctl_t;

  logic [QuoBits+1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QuoBits:0], in_vld_i};
    end
  end

  // setup: divisor, zero tests, numerator magnitudes and signs
  logic                inv;
  logic                nrm;
  logic                tiny;
  dctl_t               pctl_d;
  logic [DivBits-1:0]  pden_d;
  lane_t [3:0]         plane_d;
  logic [WordBits-1:0] mag;
  logic [NumBits-1:0]  num;

  always_comb begin
    inv           = (in_side_i.func == FUNC_INV);
    nrm           = (in_side_i.func == FUNC_NORM) || (in_side_i.func == FUNC_NLERP);
    tiny          = in_len_i <= RootBits'(tol_i);
    pctl_d.v      = in_side_i.v;
    pctl_d.flag   = in_side_i.flag;
    pctl_d.zero   = inv && (in_side_i.quad <= QuadBits'(tol_i));
    pctl_d.do_div = (inv && !pctl_d.zero) || (nrm && !tiny);
    pden_d        = inv ? in_side_i.quad : DivBits'(in_len_i);
    mag           = '0;
    num           = '0;
    for (int i = 0; i < 4; i++) begin
      mag = in_side_i.v[i][WordBits-1] ? (~in_side_i.v[i] + 1'b1) : in_side_i.v[i];
      num = {mag, {FracBits{1'b0}}};
      plane_d[i].neg = in_side_i.v[i][WordBits-1] ^ (inv && (i != 0));
      plane_d[i].big = DivBits'(num[NumBits-1:QuoBits]) >= pden_d;
      plane_d[i].rem = DivBits'(num[NumBits-1:QuoBits]);
      plane_d[i].lq  = num[QuoBits-1:0];
    end
  end

  dctl_t               pctl_q;
  logic [DivBits-1:0]  pden_q;
  lane_t [3:0]         plane_q;

  always_ff @(posedge clk_i) begin
    pctl_q  <= pctl_d;
    pden_q  <= pden_d;
    plane_q <= plane_d;
  end

  // restoring division steps, numerator bits shift out as quotient shifts in
  dctl_t               ctl_q  [QuoBits];
  logic [DivBits-1:0]  den_q  [QuoBits];
  lane_t [3:0]         lane_q [QuoBits];
  dctl_t               ctl_d  [QuoBits];
  logic [DivBits-1:0]  den_d  [QuoBits];
  lane_t [3:0]         lane_d [QuoBits];

  always_comb begin
    lane_t            cur;
    logic [DivBits:0] r;
    logic             ge;
    for (int s = 0; s < QuoBits; s++) begin
      ctl_d[s] = (s == 0) ? pctl_q : ctl_q[s-1];
      den_d[s] = (s == 0) ? pden_q : den_q[s-1];
      for (int i = 0; i < 4; i++) begin
        cur = (s == 0) ? plane_q[i] : lane_q[s-1][i];
        r   = {cur.rem, cur.lq[QuoBits-1]};
        ge  = r >= {1'b0, den_d[s]};
        lane_d[s][i]     = cur;
        lane_d[s][i].rem = ge ? DivBits'(r - {1'b0, den_d[s]}) : DivBits'(r);
        lane_d[s][i].lq  = {cur.lq[QuoBits-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < QuoBits; s++) begin
      ctl_q[s]  <= ctl_d[s];
      den_q[s]  <= den_d[s];
      lane_q[s] <= lane_d[s];
    end
  end

  // sign, saturation and result select
  dctl_t               fctl;
  lane_t               fl_lane;
  logic [QuoBits-1:0]  q;
  logic                ovf;
  logic                any_ovf;
  quat_t               qr;
  res_t                res_d;
  res_t                res_q;

  always_comb begin
    fctl    = ctl_q[QuoBits-1];
    any_ovf = 1'b0;
    qr      = '0;
    fl_lane = '0;
    q       = '0;
    ovf     = 1'b0;
    for (int i = 0; i < 4; i++) begin
      fl_lane = lane_q[QuoBits-1][i];
      q       = fl_lane.lq;
      if (fl_lane.neg) begin
        ovf = fl_lane.big || (|q[QuoBits-1:WordBits])
           || (q[WordBits-1] && (|q[WordBits-2:0]));
      end else begin
        ovf = fl_lane.big || (|q[QuoBits-1:WordBits-1]);
      end
      if (ovf) begin
        qr[i] = fl_lane.neg ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
      end else begin
        qr[i] = fl_lane.neg ? (~q[WordBits-1:0] + 1'b1) : q[WordBits-1:0];
      end
      any_ovf = any_ovf | ovf;
    end
    priority if (fctl.zero) begin
      res_d.r      = '0;
      res_d.status = ST_ZERO_INV;
    end else if (fctl.do_div) begin
      res_d.r      = qr;
      res_d.status = (fctl.flag || any_ovf) ? ST_SAT : ST_OK;
    end else begin
      res_d.r      = fctl.v;
      res_d.status = fctl.flag ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_vld_o = vld_q[QuoBits+1];
  assign out_o     = res_q;

endmodule

`default_nettype wire

// File: design/quaternion_alu.sv
// Quaternion ALU top level: register port, front pipeline, square root and
// divider pipelines. Uses qalu_pkg, qalu_front, qalu_sqrt and qalu_div.
`timescale 1ns / 1ps
`default_nettype none

// A new word may be started on every clock cycle; busy_o is never raised.
// Each word's result appears on done_o after six front stages (capture,
// multiply, reduce, blend, square, sum), 32 square root stages, one divider
// setup stage, 33 divider stages and the output register. All operations
// take the same path, so results leave in start order, one per cycle at most.
// The receiver cannot hold a result off: it must take every word in the cycle
// done_o is high. The user must write zero_tolerance over the APB port at
// byte address 0 while no word is in flight; the block does not enforce it.
module quaternion_alu import qalu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [2:0]           func_i,
  input  logic [WordBits-1:0]  a_t_i,
  input  logic [WordBits-1:0]  a_x_i,
  input  logic [WordBits-1:0]  a_y_i,
  input  logic [WordBits-1:0]  a_z_i,
  input  logic [WordBits-1:0]  b_t_i,
  input  logic [WordBits-1:0]  b_x_i,
  input  logic [WordBits-1:0]  b_y_i,
  input  logic [WordBits-1:0]  b_z_i,
  input  logic [WordBits-1:0]  weight_i,
  output logic                 done_o,
  output logic [WordBits-1:0]  r_t_o,
  output logic [WordBits-1:0]  r_x_o,
  output logic [WordBits-1:0]  r_y_o,
  output logic [WordBits-1:0]  r_z_o,
  output logic [1:0]           status_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic RegZeroTol = 1'b0;

  // configuration register
  logic [TolBits-1:0] tol_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == RegZeroTol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolBits'(1);
    end else if (cfg_we) begin
      tol_q <= pwdata[TolBits-1:0];
    end
  end

  assign prdata = (paddr[2] == RegZeroTol) ? 32'(tol_q) : '0;

  // input word
  item_t item;
  logic  in_vld;

  assign busy_o    = 1'b0;
  assign in_vld    = start_i && !busy_o;
  assign item.func = func_e'(func_i);
  assign item.a    = {a_z_i, a_y_i, a_x_i, a_t_i};
  assign item.b    = {b_z_i, b_y_i, b_x_i, b_t_i};
  assign item.w    = weight_i;

  // pipelines
  logic                front_vld;
  front_t              front;
  logic                sqrt_vld;
  side_t               side;
  logic [RootBits-1:0] len;
  res_t                res;

  qalu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (in_vld),
    .in_i      (item),
    .out_vld_o (front_vld),
    .out_o     (front)
  );

  qalu_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (front_vld),
    .in_i       (front),
    .out_vld_o  (sqrt_vld),
    .out_side_o (side),
    .out_len_o  (len)
  );

  qalu_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (sqrt_vld),
    .in_side_i (side),
    .in_len_i  (len),
    .tol_i     (tol_q),
    .out_vld_o (done_o),
    .out_o     (res)
  );

  // result word
  assign r_t_o    = res.r[0];
  assign r_x_o    = res.r[1];
  assign r_y_o    = res.r[2];
  assign r_z_o    = res.r[3];
  assign status_o = res.status;

endmodule

`default_nettype wire

// File: tb/quaternion_alu_tb.sv
// Self-checking testbench for quaternion_alu: directed table then random words,
// checked against typed table rows or a fixed-point quaternion predictor. Uses qalu_pkg.
`timescale 1ns / 1ps

module quaternion_alu_tb;
  import qalu_pkg::*;

  localparam logic [2:0] RegZeroTol  = 3'd0;
  localparam int         PipeLatency = 73;
  localparam int         StallLimit  = 2000;
  localparam int         WordsPerSet = 390;
  localparam logic [31:0] WMax = 32'h7fff_ffff;
  localparam logic [31:0] WMin = 32'h8000_0000;
  localparam logic [31:0] One  = 32'h0001_0000;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    quat_t    r;
    status_e  status;
  } qres_t;

  typedef struct packed {
    item_t  it;
    logic   typed;
    qres_t  res;
  } dir_row_t;

  logic clk_i, rst_ni, start_i, busy_o, done_o;
  logic [2:0] func_i;
  logic [31:0] a_t_i, a_x_i, a_y_i, a_z_i, b_t_i, b_x_i, b_y_i, b_z_i, weight_i;
  logic [31:0] r_t_o, r_x_o, r_y_o, r_z_o;
  logic [1:0] status_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  quaternion_alu i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i,
    .a_t_i, .a_x_i, .a_y_i, .a_z_i, .b_t_i, .b_x_i, .b_y_i, .b_z_i, .weight_i,
    .done_o, .r_t_o, .r_x_o, .r_y_o, .r_z_o, .status_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  logic [15:0] tol_q;
  qres_t       pending_q[$];
  int          err_cnt;
  int          stall_cnt;
  bit          sat_seen;

  // ---------------- quaternion predictor ----------------

  function automatic wide_t sxt(input logic [31:0] v);
    return wide_t'($signed(v));
  endfunction

  // product floored back to word scale
  function automatic wide_t fmul(input wide_t a, input wide_t b);
    return (a * b) >>> FracBits;
  endfunction

  function automatic wide_t clamp(input wide_t v);
    if (v > wide_t'(32'sh7fff_ffff)) begin
      sat_seen = 1'b1;
      return wide_t'(32'sh7fff_ffff);
    end
    if (v < -wide_t'(64'sh8000_0000)) begin
      sat_seen = 1'b1;
      return -wide_t'(64'sh8000_0000);
    end
    return v;
  endfunction

  // exact sum of squares, clamped to 64 bits
  function automatic logic [63:0] sum_sq(input wide_t q[4]);
    wide_t acc;
    acc = 0;
    for (int i = 0; i < 4; i++) acc += q[i] * q[i];
    if (acc > wide_t'({1'b0, {64{1'b1}}})) return {64{1'b1}};
    return acc[63:0];
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_len(input wide_t q[4], output wide_t r[4]);
    logic [63:0] len;
    len = root64(sum_sq(q));
    for (int i = 0; i < 4; i++) begin
      if (len <= {48'd0, tol_q}) r[i] = q[i];
      else r[i] = clamp((q[i] <<< FracBits) / $signed({64'd0, len}));
    end
  endfunction

  function automatic qres_t predict_quat(input item_t it);
    wide_t a[4], b[4], r[4], m[4];
    wide_t w, k0, k1, dot;
    logic [63:0] quad;
    qres_t res;
    sat_seen   = 1'b0;
    res.status = ST_OK;
    w = sxt(it.w);
    for (int i = 0; i < 4; i++) begin
      a[i] = sxt(it.a[i]);
      b[i] = sxt(it.b[i]);
    end
    case (it.func)
      FUNC_MUL: begin
        r[0] = clamp(fmul(a[0], b[0]) - fmul(a[1], b[1]) - fmul(a[2], b[2])
                     - fmul(a[3], b[3]));
        r[1] = clamp(fmul(a[0], b[1]) + fmul(a[1], b[0]) + fmul(a[2], b[3])
                     - fmul(a[3], b[2]));
        r[2] = clamp(fmul(a[0], b[2]) + fmul(a[2], b[0]) + fmul(a[3], b[1])
                     - fmul(a[1], b[3]));
        r[3] = clamp(fmul(a[0], b[3]) + fmul(a[3], b[0]) + fmul(a[1], b[2])
                     - fmul(a[2], b[1]));
      end
      FUNC_ADD:   for (int i = 0; i < 4; i++) r[i] = clamp(a[i] + b[i]);
      FUNC_SUB:   for (int i = 0; i < 4; i++) r[i] = clamp(a[i] - b[i]);
      FUNC_SCALE: for (int i = 0; i < 4; i++) r[i] = clamp(fmul(a[i], w));
      FUNC_CONJ: begin
        r[0] = a[0];
        for (int i = 1; i < 4; i++) r[i] = clamp(-a[i]);
      end
      FUNC_INV: begin
        quad = sum_sq(a) >> FracBits;
        if (quad <= {48'd0, tol_q}) begin
          for (int i = 0; i < 4; i++) r[i] = 0;
          res.status = ST_ZERO_INV;
        end else begin
          for (int i = 0; i < 4; i++)
            r[i] = clamp(((i == 0) ? a[0] : -a[i]) * (wide_t'(1) <<< FracBits)
                         / $signed({64'd0, quad}));
        end
      end
      FUNC_NORM: unit_len(a, r);
      default: begin
        // blend toward b, flipping b when the two point apart
        dot = 0;
        for (int i = 0; i < 4; i++) dot += a[i] * b[i];
        k0 = (wide_t'(1) <<< FracBits) - w;
        k1 = (dot > 0) ? w : -w;
        for (int i = 0; i < 4; i++) m[i] = clamp(fmul(a[i], k0) + fmul(b[i], k1));
        unit_len(m, r);
      end
    endcase
    if (res.status == ST_OK && sat_seen) res.status = ST_SAT;
    for (int i = 0; i < 4; i++) res.r[i] = r[i][31:0];
    return res;
  endfunction

  // ---------------- stimulus ----------------

  function automatic quat_t qv(input logic [31:0] t, x, y, z);
    quat_t q;
    q[0] = t; q[1] = x; q[2] = y; q[3] = z;
    return q;
  endfunction

  function automatic dir_row_t dir_row(input int n);
    dir_row_t d;
    d.it.func = FUNC_MUL;
    d.it.a    = qv(0, 0, 0, 0);
    d.it.b    = qv(0, 0, 0, 0);
    d.it.w    = 0;
    d.typed   = 1'b0;
    d.res.r   = qv(0, 0, 0, 0);
    d.res.status = ST_OK;
    case (n)
      0: d.typed = 1'b1;
      1: begin d.it.a = qv(One, 0, 0, 0); d.it.b = qv(0, One, 0, 0); end
      2: begin d.it.a = qv(WMax, WMax, WMax, WMax); d.it.b = qv(WMax, WMin, WMax, WMin); end
      3: begin
        d.it.func = FUNC_ADD;
        d.it.a = qv(WMax, WMax, WMax, WMax); d.it.b = d.it.a;
        d.typed = 1'b1; d.res.r = d.it.a; d.res.status = ST_SAT;
      end
      4: begin
        d.it.func = FUNC_SUB;
        d.it.a = qv(WMin, WMin, WMin, WMin); d.it.b = qv(WMax, WMax, WMax, WMax);
        d.typed = 1'b1; d.res.r = d.it.a; d.res.status = ST_SAT;
      end
      5: begin d.it.func = FUNC_SCALE; d.it.a = qv(WMax, WMin, 1, -1); d.it.w = WMin; end
      6: begin d.it.func = FUNC_SCALE; d.it.a = qv(One, -3, 12345, WMin); d.it.w = One; end
      7: begin
        d.it.func = FUNC_CONJ; d.it.a = qv(WMin, WMin, WMin, WMin);
        d.typed = 1'b1; d.res.r = qv(WMin, WMax, WMax, WMax); d.res.status = ST_SAT;
      end
      8: begin d.it.func = FUNC_CONJ; d.it.a = qv(1, 2, 3, WMax); end
      9: begin d.it.func = FUNC_INV; d.typed = 1'b1; d.res.status = ST_ZERO_INV; end
      10: begin
        // norm right at the tolerance counts as zero
        d.it.func = FUNC_INV; d.it.a = qv(256, 0, 0, 0);
        d.typed = 1'b1; d.res.status = ST_ZERO_INV;
      end
      11: begin d.it.func = FUNC_INV; d.it.a = qv(2 * One, 0, 0, 0); end
      12: begin d.it.func = FUNC_INV; d.it.a = qv(WMin, WMin, WMin, WMin); end
      13: begin d.it.func = FUNC_INV; d.it.a = qv(0, 300, 0, 0); end
      14: begin d.it.func = FUNC_NORM; d.typed = 1'b1; end
      15: begin
        d.it.func = FUNC_NORM; d.it.a = qv(1, 0, 0, 0);
        d.typed = 1'b1; d.res.r = d.it.a;
      end
      16: begin d.it.func = FUNC_NORM; d.it.a = qv(3 * One, 4 * One, 0, 0); end
      17: begin d.it.func = FUNC_NORM; d.it.a = qv(WMax, WMax, WMax, WMax); end
      18: begin d.it.func = FUNC_NORM; d.it.a = qv(WMin, WMin, WMin, WMin); end
      19: begin
        d.it.func = FUNC_NLERP; d.it.a = qv(One, 0, 0, 0);
        d.it.b = qv(-One, 0, 0, 0); d.it.w = 32'h0000_8000;
      end
      20: begin
        d.it.func = FUNC_NLERP; d.it.a = qv(WMax, 0, WMin, 5);
        d.it.b = qv(WMax, WMax, WMax, WMax); d.it.w = WMax;
      end
      21: begin
        d.it.func = FUNC_NLERP; d.it.a = qv(One, One, 0, 0);
        d.it.b = qv(0, One, One, 0); d.it.w = WMin;
      end
      default: begin d.it.func = FUNC_NLERP; d.typed = 1'b1; end
    endcase
    return d;
  endfunction

  localparam int DirRows = 23;

  function automatic logic [31:0] rnd_comp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      7:          return 32'($signed($urandom_range(0, 600)) - 300);
      8: begin
        case ($urandom_range(0, 3))
          0: return WMax;
          1: return WMin;
          2: return 0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom_range(0, 1) ? One : -One;
    endcase
  endfunction

  function automatic item_t rnd_item();
    item_t it;
    it.func = func_e'($urandom_range(0, 7));
    for (int i = 0; i < 4; i++) begin
      it.a[i] = rnd_comp();
      it.b[i] = rnd_comp();
    end
    if (it.func == FUNC_NLERP && $urandom_range(0, 3) != 0) it.w = $urandom_range(0, 65536);
    else it.w = rnd_comp();
    return it;
  endfunction

  // one word over the start handshake, with a random idle gap ahead of it
  task automatic send_word(input item_t it, input logic typed, input qres_t res);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    func_i   <= it.func;
    a_t_i    <= it.a[0];
    a_x_i    <= it.a[1];
    a_y_i    <= it.a[2];
    a_z_i    <= it.a[3];
    b_t_i    <= it.b[0];
    b_x_i    <= it.b[1];
    b_y_i    <= it.b[2];
    b_z_i    <= it.b[3];
    weight_i <= it.w;
    do @(posedge clk_i); while (busy_o);
    pending_q.push_back(typed ? res : predict_quat(it));
  endtask

  task automatic write_tol(input logic [15:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= RegZeroTol;
    pwdata  <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tol_q = v;
  endtask

  // let the pipeline drain before touching the register
  task automatic drain();
    start_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (PipeLatency + 8) @(posedge clk_i);
  endtask

  // ---------------- result checking ----------------

  always @(posedge clk_i) begin
    qres_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result word");
        err_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (r_t_o !== exp_r.r[0]) begin
          $error("r_t exp %h got %h", exp_r.r[0], r_t_o); err_cnt++;
        end
        if (r_x_o !== exp_r.r[1]) begin
          $error("r_x exp %h got %h", exp_r.r[1], r_x_o); err_cnt++;
        end
        if (r_y_o !== exp_r.r[2]) begin
          $error("r_y exp %h got %h", exp_r.r[2], r_y_o); err_cnt++;
        end
        if (r_z_o !== exp_r.r[3]) begin
          $error("r_z exp %h got %h", exp_r.r[3], r_z_o); err_cnt++;
        end
        if (status_o !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, status_o); err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    dir_row_t d;
    logic [15:0] tols[4];
    err_cnt   = 0;
    stall_cnt = 0;
    tol_q     = 16'd1;
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    func_i    = FUNC_MUL;
    {a_t_i, a_x_i, a_y_i, a_z_i} = '0;
    {b_t_i, b_x_i, b_y_i, b_z_i} = '0;
    weight_i  = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = RegZeroTol;
    pwdata    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, then random words, under the reset tolerance
    for (int n = 0; n < DirRows; n++) begin
      d = dir_row(n);
      send_word(d.it, d.typed, d.res);
    end
    for (int n = 0; n < WordsPerSet; n++) send_word(rnd_item(), 1'b0, '0);

    // further tolerance settings, extremes included
    tols[0] = 16'd0;
    tols[1] = 16'hffff;
    tols[2] = $urandom_range(2, 65534);
    tols[3] = 16'd300;
    foreach (tols[p]) begin
      drain();
      write_tol(tols[p]);
      for (int n = 0; n < WordsPerSet; n++) send_word(rnd_item(), 1'b0, '0);
    end

    start_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (PipeLatency + 8) @(posedge clk_i);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
